// ===== design/assert_macros.svh =====
// Assertion macros shared by the quadtree decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define QTD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("qtd assertion failed");

// Check that a condition in one cycle implies another in the next.
`define QTD_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("qtd assertion failed");

`endif

// ===== design/qtd_pkg.sv =====
// Shared constants and types of the quadtree decoder.
`default_nettype none

package qtd_pkg;

  localparam int CODE_W   = 8;
  localparam int COORD_W  = 8;
  localparam int FSIDE_W  = 9;
  localparam int COLOR_W  = 8;
  localparam int LOG_W    = 4;

  localparam int DEF_MAX_SIDE_LOG = 8;
  localparam int DEF_QUEUE_DEPTH  = 65536;

  localparam logic [LOG_W-1:0] RESET_SIDE_LOG = 4'd8;

  // Square queue control from the decoder.
  typedef struct packed {
    logic arm;
    logic pop;
    logic split;
  } qtd_qctl_t;

  // One fill command word.
  typedef struct packed {
    logic [COORD_W-1:0] fill_x;
    logic [COORD_W-1:0] fill_y;
    logic [FSIDE_W-1:0] fill_side;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               image_done;
    logic               malformed;
  } qtd_fill_t;

endpackage

`default_nettype wire

// ===== design/qtd_if.sv =====
// Stream channel interfaces: code bytes in, fill commands out.
`default_nettype none

interface qtd_code_if;
  logic                       valid;
  logic                       ready;
  logic [qtd_pkg::CODE_W-1:0] code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink (input valid, input code_byte, output ready);
endinterface

interface qtd_fill_if;
  logic                        valid;
  logic                        ready;
  logic [qtd_pkg::COORD_W-1:0] fill_x;
  logic [qtd_pkg::COORD_W-1:0] fill_y;
  logic [qtd_pkg::FSIDE_W-1:0] fill_side;
  logic [qtd_pkg::COLOR_W-1:0] red;
  logic [qtd_pkg::COLOR_W-1:0] green;
  logic [qtd_pkg::COLOR_W-1:0] blue;
  logic                        image_done;
  logic                        malformed;

  modport source (output valid, output fill_x, output fill_y, output fill_side,
                  output red, output green, output blue, output image_done,
                  output malformed, input ready);
  modport sink (input valid, input fill_x, input fill_y, input fill_side,
                input red, input green, input blue, input image_done,
                input malformed, output ready);
endinterface

`default_nettype wire

// ===== design/qtd_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none

module qtd_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 16386
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]           wdata,
  input  wire logic                       re,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output      logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/qtd_square_queue.sv =====
// Pending square queue: head group and next group in registers, the rest in RAM.
`default_nettype none

`include "assert_macros.svh"

module qtd_square_queue #(
  parameter int MAX_SIDE_LOG = qtd_pkg::DEF_MAX_SIDE_LOG,
  parameter int QUEUE_DEPTH  = qtd_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire qtd_pkg::qtd_qctl_t                            ctl,
  input  wire logic [2*MAX_SIDE_LOG+qtd_pkg::LOG_W-1:0]      root,
  output      logic [2*MAX_SIDE_LOG+qtd_pkg::LOG_W-1:0]      cur_sq,
  output      logic                                          cur_valid
);

  // A split stores its parent once; the four children are derived from it.
  localparam int SQ_W      = 2*MAX_SIDE_LOG + qtd_pkg::LOG_W;
  localparam int GRP_DEPTH = QUEUE_DEPTH/4 + 2;
  localparam int PTR_W     = $clog2(GRP_DEPTH);
  localparam int CNT_W     = $clog2(GRP_DEPTH + 1);

  logic             head_valid, head_valid_next;
  logic [SQ_W-1:0]  head_sq, head_sq_next;
  logic             head_single, head_single_next;
  logic [1:0]       head_child, head_child_next;
  logic             nv_valid, nv_valid_next;
  logic [SQ_W-1:0]  nv_sq, nv_sq_next;
  logic             inflight, inflight_next;
  logic [PTR_W-1:0] rptr, rptr_next;
  logic [PTR_W-1:0] wptr, wptr_next;
  logic [CNT_W-1:0] mcnt, mcnt_next;

  logic             rd_en, wr_en;
  logic [SQ_W-1:0]  rdata;
  logic             adv_head, s2v, keep2, to_head;
  logic [SQ_W-1:0]  s2d;

  logic [MAX_SIDE_LOG-1:0]   hx, hy, d;
  logic [qtd_pkg::LOG_W-1:0] hk, ck;

  qtd_ram #(
    .WIDTH (SQ_W),
    .DEPTH (GRP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wptr),
    .wdata (cur_sq),
    .re    (rd_en),
    .raddr (rptr),
    .rdata (rdata)
  );

  // Current square: the head itself or one child of the head parent.
  always_comb begin
    hx = head_sq[MAX_SIDE_LOG-1:0];
    hy = head_sq[2*MAX_SIDE_LOG-1:MAX_SIDE_LOG];
    hk = head_sq[SQ_W-1:2*MAX_SIDE_LOG];
    ck = hk - qtd_pkg::LOG_W'(1);
    d  = MAX_SIDE_LOG'(1) << ck;
    if (head_single) begin
      cur_sq = head_sq;
    end else begin
      case (head_child)
        2'd0:    cur_sq = {ck, hy, hx};
        2'd1:    cur_sq = {ck, hy, hx + d};
        2'd2:    cur_sq = {ck, hy + d, hx + d};
        default: cur_sq = {ck, hy + d, hx};
      endcase
    end
  end

  assign cur_valid = head_valid;

  // Second slot: the next register, or RAM data arriving this cycle.
  assign s2v      = nv_valid || inflight;
  assign s2d      = nv_valid ? nv_sq : rdata;
  assign adv_head = ctl.pop && (head_single || (head_child == 2'd3));
  assign keep2    = s2v && !adv_head;
  assign to_head  = adv_head && !s2v && ctl.split;

  always_comb begin
    head_valid_next  = head_valid;
    head_sq_next     = head_sq;
    head_single_next = head_single;
    head_child_next  = head_child;
    nv_valid_next    = nv_valid;
    nv_sq_next       = nv_sq;
    rptr_next        = rptr;
    wptr_next        = wptr;
    mcnt_next        = mcnt;
    rd_en            = 1'b0;
    wr_en            = 1'b0;
    if (ctl.arm) begin
      head_valid_next  = 1'b1;
      head_sq_next     = root;
      head_single_next = 1'b1;
      head_child_next  = 2'd0;
      nv_valid_next    = 1'b0;
      rptr_next        = '0;
      wptr_next        = '0;
      mcnt_next        = '0;
    end else begin
      if (ctl.pop) begin
        if (!adv_head) begin
          head_child_next = head_child + 2'd1;
        end else if (s2v) begin
          head_sq_next     = s2d;
          head_single_next = 1'b0;
          head_child_next  = 2'd0;
        end else if (ctl.split) begin
          // forward the fresh group straight to the head
          head_sq_next     = cur_sq;
          head_single_next = 1'b0;
          head_child_next  = 2'd0;
        end else begin
          head_valid_next = 1'b0;
        end
      end
      if (!keep2 && (mcnt != '0)) begin
        rd_en         = 1'b1;
        nv_valid_next = 1'b0;
      end else if (!keep2 && ctl.split && !to_head) begin
        nv_sq_next    = cur_sq;
        nv_valid_next = 1'b1;
      end else if (keep2) begin
        nv_sq_next    = s2d;
        nv_valid_next = 1'b1;
      end else begin
        nv_valid_next = 1'b0;
      end
      wr_en = ctl.split && !to_head && (keep2 || (mcnt != '0));
      if (rd_en) begin
        rptr_next = (rptr == PTR_W'(GRP_DEPTH - 1)) ? '0 : rptr + PTR_W'(1);
      end
      if (wr_en) begin
        wptr_next = (wptr == PTR_W'(GRP_DEPTH - 1)) ? '0 : wptr + PTR_W'(1);
      end
      mcnt_next = mcnt + CNT_W'(wr_en) - CNT_W'(rd_en);
    end
    inflight_next = rd_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid  <= 1'b1;
      head_sq     <= root;
      head_single <= 1'b1;
      head_child  <= 2'd0;
      nv_valid    <= 1'b0;
      inflight    <= 1'b0;
      rptr        <= '0;
      wptr        <= '0;
      mcnt        <= '0;
    end else begin
      head_valid  <= head_valid_next;
      head_sq     <= head_sq_next;
      head_single <= head_single_next;
      head_child  <= head_child_next;
      nv_valid    <= nv_valid_next;
      nv_sq       <= nv_sq_next;
      inflight    <= inflight_next;
      rptr        <= rptr_next;
      wptr        <= wptr_next;
      mcnt        <= mcnt_next;
    end
  end

  `QTD_ASSERT(a_no_same_entry, clk, rst, !(wr_en && rd_en) || (wptr != rptr))
  `QTD_ASSERT(a_next_needs_head, clk, rst, !s2v || head_valid)
  `QTD_ASSERT(a_one_second_slot, clk, rst, !(nv_valid && inflight))

endmodule

`default_nettype wire

// ===== design/qtd_out_buf.sv =====
// Two-word output buffer between the decoder and the fill channel.
`default_nettype none

module qtd_out_buf (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire qtd_pkg::qtd_fill_t in_data,
  output      logic               full,
  qtd_fill_if.source              fill
);

  qtd_pkg::qtd_fill_t slot0, slot1;
  qtd_pkg::qtd_fill_t slot0_next, slot1_next;
  logic [1:0]         cnt, cnt_next;
  logic               pop;

  assign pop  = fill.valid && fill.ready;
  assign full = (cnt == 2'd2);

  always_comb begin
    // shift out first, then append behind what is left
    slot0_next = pop ? slot1 : slot0;
    slot1_next = slot1;
    cnt_next   = cnt - 2'(pop);
    if (in_valid) begin
      if (cnt_next == 2'd0) begin
        slot0_next = in_data;
      end else begin
        slot1_next = in_data;
      end
      cnt_next = cnt_next + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt   <= cnt_next;
      slot0 <= slot0_next;
      slot1 <= slot1_next;
    end
  end

  assign fill.valid      = (cnt != 2'd0);
  assign fill.fill_x     = slot0.fill_x;
  assign fill.fill_y     = slot0.fill_y;
  assign fill.fill_side  = slot0.fill_side;
  assign fill.red        = slot0.red;
  assign fill.green      = slot0.green;
  assign fill.blue       = slot0.blue;
  assign fill.image_done = slot0.image_done;
  assign fill.malformed  = slot0.malformed;

endmodule

`default_nettype wire

// ===== design/quadtree_image_decoder_unit.sv =====
// Quadtree image decoder: breadth-first code bytes in, square fill commands out.
//
// Channel code carries one byte of the code stream per word. Channel fill
// carries one fill command (square position, side, color) per leaf, and one
// last word flagged malformed if a split is asked for at side 1 or the
// pending queue would overflow; the decoder then ignores bytes until re-armed.
// A write on cfg_we/cfg_wdata sets side_log (saturated at MAX_SIDE_LOG) and
// re-arms the decoder with the root square; reset arms it with side 256.
// Throughput is one byte per cycle while the output buffer has room: each
// byte does at most one queue pop and one group push, the push being a single
// write of the parent square to the pending-square RAM, so its one write port
// and one read port set the rate. A fill word is registered into the output
// buffer when the blue byte (or the bad split byte) is accepted. Reset needs
// no clearing pass: the RAM is only read at entries written since the last
// arm. Bytes after the image is complete are taken and dropped.
// The output buffer holds two words; while it is full, flag and blue bytes
// wait (even when fill.ready is high), and red and green bytes still flow.
`default_nettype none

`include "assert_macros.svh"

module quadtree_image_decoder_unit #(
  parameter int MAX_SIDE_LOG = qtd_pkg::DEF_MAX_SIDE_LOG,
  parameter int QUEUE_DEPTH  = qtd_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [qtd_pkg::LOG_W-1:0] cfg_wdata,
  qtd_code_if.sink                       code,
  qtd_fill_if.source                     fill
);

  localparam int SQ_W  = 2*MAX_SIDE_LOG + qtd_pkg::LOG_W;
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {PH_FLAG, PH_RED, PH_GREEN, PH_BLUE} phase_t;

  phase_t                      phase;
  logic [qtd_pkg::COLOR_W-1:0] held_red, held_green;
  logic                        halted;
  logic [OCC_W-1:0]            occ;

  logic                        accept, active, flag_zero, bad;
  logic [OCC_W:0]              occ_plus3;
  logic [qtd_pkg::LOG_W-1:0]   arm_log, root_log;
  logic [SQ_W-1:0]             root, cur_sq;
  logic                        cur_valid;
  logic [MAX_SIDE_LOG-1:0]     cx, cy;
  logic [qtd_pkg::LOG_W-1:0]   ck;
  logic [MAX_SIDE_LOG+7:0]     cx_w, cy_w;
  qtd_pkg::qtd_qctl_t          qctl;
  qtd_pkg::qtd_fill_t          res;
  logic                        res_valid, out_full;

  assign arm_log  = rst ? qtd_pkg::RESET_SIDE_LOG : cfg_wdata;
  assign root_log = (arm_log > qtd_pkg::LOG_W'(MAX_SIDE_LOG)) ?
                    qtd_pkg::LOG_W'(MAX_SIDE_LOG) : arm_log;
  assign root     = {root_log, {(2*MAX_SIDE_LOG){1'b0}}};

  assign cx   = cur_sq[MAX_SIDE_LOG-1:0];
  assign cy   = cur_sq[2*MAX_SIDE_LOG-1:MAX_SIDE_LOG];
  assign ck   = cur_sq[SQ_W-1:2*MAX_SIDE_LOG];
  assign cx_w = {8'd0, cx};
  assign cy_w = {8'd0, cy};

  assign accept    = code.valid && code.ready;
  assign active    = !halted && (occ != '0);
  assign flag_zero = (phase == PH_FLAG) && (code.code_byte == '0);
  assign occ_plus3 = {1'b0, occ} + (OCC_W+1)'(3);
  assign bad       = (ck == '0) || (occ_plus3 > (OCC_W+1)'(QUEUE_DEPTH));

  // Hold flag and blue bytes while no output room is left.
  assign code.ready = !out_full || halted || (occ == '0) ||
                      (phase inside {PH_RED, PH_GREEN});

  always_comb begin
    qctl.arm   = cfg_we;
    qctl.split = !cfg_we && accept && active && flag_zero && !bad;
    qctl.pop   = qctl.split || (!cfg_we && accept && active && (phase == PH_BLUE));
  end

  always_comb begin
    res_valid      = !cfg_we && accept && active &&
                     ((flag_zero && bad) || (phase == PH_BLUE));
    res.fill_x     = cx_w[7:0];
    res.fill_y     = cy_w[7:0];
    res.fill_side  = qtd_pkg::FSIDE_W'(1) << ck;
    res.malformed  = (phase == PH_FLAG);
    res.red        = res.malformed ? '0 : held_red;
    res.green      = res.malformed ? '0 : held_green;
    res.blue       = res.malformed ? '0 : code.code_byte;
    res.image_done = (phase == PH_BLUE) && (occ == OCC_W'(1));
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      phase      <= PH_FLAG;
      held_red   <= '0;
      held_green <= '0;
      halted     <= 1'b0;
      occ        <= OCC_W'(1);
    end else if (accept && active) begin
      unique case (phase)
        PH_FLAG: begin
          if (code.code_byte != '0) begin
            phase <= PH_RED;
          end else if (bad) begin
            halted <= 1'b1;
          end else begin
            occ <= occ + OCC_W'(3);
          end
        end
        PH_RED: begin
          held_red <= code.code_byte;
          phase    <= PH_GREEN;
        end
        PH_GREEN: begin
          held_green <= code.code_byte;
          phase      <= PH_BLUE;
        end
        PH_BLUE: begin
          occ   <= occ - OCC_W'(1);
          phase <= PH_FLAG;
        end
        default: phase <= PH_FLAG;
      endcase
    end
  end

  qtd_square_queue #(
    .MAX_SIDE_LOG (MAX_SIDE_LOG),
    .QUEUE_DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl       (qctl),
    .root      (root),
    .cur_sq    (cur_sq),
    .cur_valid (cur_valid)
  );

  qtd_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (res_valid),
    .in_data  (res),
    .full     (out_full),
    .fill     (fill)
  );

  `QTD_ASSERT(a_head_tracks_occ, clk, rst, (occ != '0) == cur_valid)
  `QTD_ASSERT(a_room_for_word, clk, rst, !res_valid || !out_full)
  `QTD_ASSERT_NEXT(a_halt_is_silent, clk, rst, halted && !cfg_we, !res_valid)

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for quadtree_image_decoder_unit: predicted fill words vs. DUT output.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LOG       = qtd_pkg::DEF_MAX_SIDE_LOG;
  localparam int SQ_DEPTH      = qtd_pkg::DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BYTES  = 700;
  localparam int HOLD_OFF_LEN  = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_GUARD   = 5000;

  typedef enum logic [1:0] {PH_FLAG, PH_RED, PH_GREEN, PH_BLUE} byte_phase_t;
  typedef enum int {SHAPE_FULL, SHAPE_TREE, SHAPE_BROKEN, SHAPE_CUT, SHAPE_NOISE} shape_t;
  typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_t;

  typedef struct packed {
    logic [qtd_pkg::COORD_W-1:0] x;
    logic [qtd_pkg::COORD_W-1:0] y;
    logic [qtd_pkg::LOG_W-1:0]   k;
  } square_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      cfg_we;
  logic [qtd_pkg::LOG_W-1:0] cfg_wdata;

  qtd_code_if code_ch ();
  qtd_fill_if fill_ch ();

  quadtree_image_decoder_unit uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .code(code_ch),
    .fill(fill_ch)
  );

  // Predicted decoder state
  square_t                      squares_pending[$];
  qtd_pkg::qtd_fill_t           fills_due[$];
  byte_phase_t                  phase;
  logic [qtd_pkg::COLOR_W-1:0]  held_r;
  logic [qtd_pkg::COLOR_W-1:0]  held_g;
  logic                         halted;
  logic [qtd_pkg::LOG_W-1:0]    side_log_reg;

  int errors = 0;
  int bytes_decoded = 0;
  int fills_checked = 0;
  int malformed_seen = 0;
  int images_finished = 0;
  int cycles = 0;
  int burst_left = 0;
  logic [15:0] logs_written = '0;

  int       hold_off_asks = 0;
  int       hold_off_served = 0;
  int       hold_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_run = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d fill words outstanding", $time, cycles,
               fills_due.size());
      $display("quadtree_image_decoder_unit verification failed");
      $finish;
    end
  end

  function automatic void arm_decoder();
    square_t root;
    root.x = '0;
    root.y = '0;
    root.k = (side_log_reg > MAX_LOG) ? qtd_pkg::LOG_W'(MAX_LOG) : side_log_reg;
    squares_pending.delete();
    squares_pending.push_back(root);
    phase = PH_FLAG;
    held_r = '0;
    held_g = '0;
    halted = 1'b0;
  endfunction

  function automatic void queue_fill(square_t sq, logic [qtd_pkg::COLOR_W-1:0] r,
                                     logic [qtd_pkg::COLOR_W-1:0] g,
                                     logic [qtd_pkg::COLOR_W-1:0] b, logic done, logic bad);
    qtd_pkg::qtd_fill_t f;
    f.fill_x     = sq.x;
    f.fill_y     = sq.y;
    f.fill_side  = qtd_pkg::FSIDE_W'(1) << sq.k;
    f.red        = r;
    f.green      = g;
    f.blue       = b;
    f.image_done = done;
    f.malformed  = bad;
    fills_due.push_back(f);
  endfunction

  // Advance the predicted decoder by one byte; return 1 if the byte was not dropped.
  function automatic bit decode_byte(logic [qtd_pkg::CODE_W-1:0] b);
    square_t                     head;
    square_t                     child;
    logic [qtd_pkg::COORD_W-1:0] half;
    if (halted || squares_pending.size() == 0) return 1'b0;
    head = squares_pending[0];
    case (phase)
      PH_FLAG: begin
        if (b != '0) begin
          phase = PH_RED;
        end else if (head.k == 0 || squares_pending.size() + 3 > SQ_DEPTH) begin
          halted = 1'b1;
          queue_fill(head, '0, '0, '0, 1'b0, 1'b1);
        end else begin
          void'(squares_pending.pop_front());
          half = qtd_pkg::COORD_W'(1) << (head.k - 1);
          child.k = head.k - 1;
          child.x = head.x;
          child.y = head.y;
          squares_pending.push_back(child);
          child.x = head.x + half;
          squares_pending.push_back(child);
          child.y = head.y + half;
          squares_pending.push_back(child);
          child.x = head.x;
          squares_pending.push_back(child);
        end
      end
      PH_RED: begin
        held_r = b;
        phase = PH_GREEN;
      end
      PH_GREEN: begin
        held_g = b;
        phase = PH_BLUE;
      end
      default: begin
        void'(squares_pending.pop_front());
        phase = PH_FLAG;
        queue_fill(head, held_r, held_g, b, squares_pending.size() == 0, 1'b0);
      end
    endcase
    return 1'b1;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  // Fill word checker
  always @(posedge clk) begin
    qtd_pkg::qtd_fill_t want;
    if (!rst && fill_ch.valid && fill_ch.ready) begin
      if (fill_ch.image_done === 1'b1) images_finished++;
      if (fill_ch.malformed === 1'b1) malformed_seen++;
      if (fills_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected fill word x=%h y=%h side=%h", $time, fill_ch.fill_x,
                 fill_ch.fill_y, fill_ch.fill_side);
      end else begin
        want = fills_due.pop_front();
        check_field("fill_x", want.fill_x, fill_ch.fill_x);
        check_field("fill_y", want.fill_y, fill_ch.fill_y);
        check_field("fill_side", want.fill_side, fill_ch.fill_side);
        check_field("red", want.red, fill_ch.red);
        check_field("green", want.green, fill_ch.green);
        check_field("blue", want.blue, fill_ch.blue);
        check_field("image_done", want.image_done, fill_ch.image_done);
        check_field("malformed", want.malformed, fill_ch.malformed);
        fills_checked++;
      end
    end
  end

  // Fill channel receiver: random stall runs, plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_off_asks != hold_off_served) begin
      hold_off_served = hold_off_asks;
      hold_left = HOLD_OFF_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      fill_ch.ready <= 1'b0;
    end else begin
      if (rx_run == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        rx_run = $urandom_range(4, 40);
      end
      rx_run--;
      case (rx_mode)
        RX_OPEN: fill_ch.ready <= 1'b1;
        RX_CHOPPY: fill_ch.ready <= 1'($urandom_range(0, 1));
        default: fill_ch.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Offer one code word in bursts with random gaps; called and returns at a falling edge.
  task automatic send_code(input logic [qtd_pkg::CODE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        code_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    code_ch.valid <= 1'b1;
    code_ch.code_byte <= b;
    @(posedge clk);
    while (!code_ch.ready) @(posedge clk);
    if (decode_byte(b)) bytes_decoded++;
    burst_left--;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted fill word has come out.
  task automatic settle();
    int n;
    code_ch.valid <= 1'b0;
    burst_left = 0;
    for (n = 0; n < DRAIN_GUARD && fills_due.size() > 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fills_due.size() > 0) begin
      errors++;
      $display("%0t: %0d expected fill words never arrived", $time, fills_due.size());
      fills_due.delete();
    end
  endtask

  task automatic write_side_log(input logic [qtd_pkg::LOG_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    side_log_reg = v;
    arm_decoder();
    logs_written[v] = 1'b1;
  endtask

  task automatic send_image(input shape_t shape, input int budget);
    int                         sent;
    square_t                    head;
    logic [qtd_pkg::CODE_W-1:0] b;
    sent = 0;
    while (sent < budget && !halted && squares_pending.size() > 0) begin
      head = squares_pending[0];
      case (shape)
        SHAPE_NOISE: b = 8'($urandom_range(0, 255));
        default: begin
          if (phase != PH_FLAG) begin
            b = 8'($urandom_range(0, 255));
          end else if (head.k == 0) begin
            if (shape == SHAPE_BROKEN && $urandom_range(0, 3) == 0) b = '0;
            else b = 8'($urandom_range(1, 255));
          end else if (shape == SHAPE_FULL) begin
            b = (head.k >= 2) ? 8'd0 : 8'($urandom_range(1, 255));
          end else begin
            // split eagerly while the queue is short, rarely once it grows
            if ($urandom_range(0, 7) < (squares_pending.size() < 6 ? 6 : 1)) b = '0;
            else b = 8'($urandom_range(1, 255));
          end
        end
      endcase
      send_code(b);
      sent++;
    end
    // trailing bytes, dropped once the image is complete or halted
    repeat ($urandom_range(0, 3)) send_code(8'($urandom_range(0, 255)));
  endtask

  task automatic test_reset_root_leaf();
    send_code(8'hFF);
    send_code(8'h00);
    send_code(8'hFF);
    send_code(8'h5A);
    send_code(8'h00);
  endtask

  task automatic test_unit_side_split();
    write_side_log(4'd0);
    send_code(8'h00);
    send_code(8'h00);
  endtask

  task automatic test_quadrant_order();
    logic [qtd_pkg::CODE_W-1:0] flags [4] = '{8'h01, 8'h80, 8'h7F, 8'hFF};
    logic [qtd_pkg::CODE_W-1:0] reds [4]  = '{8'h00, 8'hFF, 8'h55, 8'hAA};
    logic [qtd_pkg::CODE_W-1:0] greens [4] = '{8'hFF, 8'h00, 8'hAA, 8'h55};
    logic [qtd_pkg::CODE_W-1:0] blues [4] = '{8'h0F, 8'hF0, 8'h3C, 8'hC3};
    write_side_log(4'd1);
    send_code(8'h00);
    for (int i = 0; i < 4; i++) begin
      send_code(flags[i]);
      send_code(reds[i]);
      send_code(greens[i]);
      send_code(blues[i]);
    end
  endtask

  task automatic test_saturated_side();
    write_side_log(4'd15);
    send_code(8'h01);
    send_code(8'h02);
    send_code(8'h03);
    send_code(8'h04);
  endtask

  task automatic test_output_backpressure();
    write_side_log(4'd3);
    hold_off_asks++;
    send_image(SHAPE_FULL, 300);
  endtask

  task automatic test_random_images();
    int                        goal;
    int                        pick;
    int                        budget;
    shape_t                    shape;
    logic [qtd_pkg::LOG_W-1:0] side;
    goal = bytes_decoded + RANDOM_BYTES;
    while (bytes_decoded < goal) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) shape = SHAPE_NOISE;
      else if (pick == 1) shape = SHAPE_CUT;
      else if (pick <= 3) shape = SHAPE_BROKEN;
      else shape = SHAPE_TREE;
      pick = $urandom_range(0, 19);
      if (shape == SHAPE_BROKEN) side = qtd_pkg::LOG_W'($urandom_range(0, 3));
      else if (pick <= 1) side = '0;
      else if (pick <= 13) side = qtd_pkg::LOG_W'($urandom_range(1, 4));
      else if (pick <= 17) side = qtd_pkg::LOG_W'($urandom_range(5, 8));
      else side = qtd_pkg::LOG_W'($urandom_range(9, 15));
      budget = (shape == SHAPE_CUT) ? $urandom_range(1, 24) : 300;
      write_side_log(side);
      send_image(shape, budget);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    code_ch.valid = 1'b0;
    code_ch.code_byte = '0;
    fill_ch.ready = 1'b0;
    side_log_reg = qtd_pkg::RESET_SIDE_LOG;
    arm_decoder();
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    test_reset_root_leaf();
    test_unit_side_split();
    test_quadrant_order();
    test_saturated_side();
    test_output_backpressure();
    test_random_images();
    settle();

    $display("Run covered %0d decoded code bytes and %0d checked fill words", bytes_decoded,
             fills_checked);
    $display("(%0d images finished, %0d malformed stops, %0d of 16 side_log codes written).",
             images_finished, malformed_seen, $countones(logs_written));
    if (errors == 0) begin
      $display("quadtree_image_decoder_unit verification clean");
    end else begin
      $display("quadtree_image_decoder_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/qtd_pkg.sv
design/qtd_if.sv
design/qtd_ram.sv
design/qtd_square_queue.sv
design/qtd_out_buf.sv
design/quadtree_image_decoder_unit.sv
bench/tb.sv
